@@ rtl/fan_tach_rpm_meter_core_assert.svh @@
// Assertion macros for the RTL of the fan tachometer meter.
`ifndef FAN_TACH_RPM_METER_CORE_ASSERT_SVH
`define FAN_TACH_RPM_METER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTRM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FTRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/fantach_pkg.sv @@
package fantach_pkg;

   localparam int unsigned MICROS_PER_MINUTE = 60000000;

   localparam int unsigned TIME_US_WIDTH  = 32;
   localparam int unsigned DEBOUNCE_WIDTH = 16;
   localparam int unsigned PPR_WIDTH      = 4;
   localparam int unsigned RPM_WIDTH      = 16;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CSR_ADDR_WIDTH = 3;

   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_PPR      = 1'b1;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd800;
   localparam logic [PPR_WIDTH-1:0]      PPR_RESET      = 4'd2;

   localparam logic MODE_PULSE  = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   // The blend sum 7*old + 3*instant needs four bits above the rpm value.
   localparam int unsigned SUM_GUARD_BITS = 4;
   localparam int unsigned BLEND_OLD      = 7;
   localparam int unsigned BLEND_NEW      = 3;
   localparam int unsigned BLEND_DIVISOR  = 10;

endpackage

@@ rtl/fan_tach_rpm_meter_core.sv @@
// Fan tachometer rpm meter.
// The req channel carries one item per transfer: req_mode low is a tach edge
// with its microsecond timestamp in req_time_us, req_mode high asks for an
// rpm update. An edge produces no result and is kept as the new period only
// when it lies at least debounce_us after the last kept edge. An update
// produces one rsp transfer carrying rsp_rpm, the integer part of the
// smoothed speed.
// An update first forms period * pulses_per_rev, then a restoring divider
// retires one quotient bit per cycle, first for the instant speed; the blend
// sum is then formed and the divider divides it by ten. When no period has
// been measured yet, the update skips the division and reports the speed as
// it stands. One item is worked on at a time; req_stall is high while an
// update is in progress.
// The result waits in an output register, so a stalled receiver does not
// block new edges; a following update finishes and then waits until the
// output register is free. Reset is synchronous: it restores debounce_us to
// 800 and pulses_per_rev to 2, and clears the period, last edge and speed.
// Configuration registers are at byte addresses 0 and 4 of the csr port.
`include "fan_tach_rpm_meter_core_assert.svh"

module fan_tach_rpm_meter_core
   import fantach_pkg::*;
#(
   parameter int unsigned RPM_FRAC_BITS = 8,
   parameter int unsigned TIME_WIDTH    = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [TIME_US_WIDTH-1:0]    req_time_us,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [RPM_WIDTH-1:0]        rsp_rpm,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                        csr_pready
);

   localparam int unsigned QW   = RPM_WIDTH + RPM_FRAC_BITS;
   localparam int unsigned SUMW = QW + SUM_GUARD_BITS;
   localparam int unsigned DW   = TIME_WIDTH + PPR_WIDTH;
   localparam int unsigned CNTW = $clog2(SUMW);

   localparam int unsigned NUM_HIGH  = MICROS_PER_MINUTE >> RPM_WIDTH;
   localparam int unsigned NUM_LOW16 = MICROS_PER_MINUTE % (1 << RPM_WIDTH);
   localparam logic [QW-1:0] NUM_LOW = QW'(NUM_LOW16) << RPM_FRAC_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_QUOT  = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_BLEND = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ff, debounce_in;
   logic [PPR_WIDTH-1:0]      ppr_ff, ppr_in;
   logic [TIME_WIDTH-1:0]     last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0]     period_ff, period_in;
   logic [QW-1:0]             smoothed_ff, smoothed_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RPM_WIDTH-1:0]      rsp_rpm_ff, rsp_rpm_in;

   logic [DW-1:0]             rem_ff, rem_in;
   logic [DW-1:0]             dvs_ff, dvs_in;
   logic [SUMW-1:0]           dvd_ff, dvd_in;
   logic [SUMW-1:0]           quo_ff, quo_in;
   logic [CNTW-1:0]           cnt_ff, cnt_in;
   logic                      sat_ff, sat_in;

   logic                      req_take;
   logic                      csr_write;
   logic                      out_free;
   logic [TIME_WIDTH-1:0]     edge_time;
   logic [TIME_WIDTH-1:0]     edge_delta;
   logic [PPR_WIDTH-1:0]      ppr_eff;
   logic [DW-1:0]             product;
   logic [DW:0]               trial;
   logic                      trial_fits;
   logic [DW-1:0]             step_rem;
   logic [SUMW-1:0]           step_quo;
   logic [QW-1:0]             instant;
   logic [SUMW-1:0]           old_ext;
   logic [SUMW-1:0]           new_ext;
   logic [SUMW-1:0]           blend_sum;
   logic                      div_active;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rpm    = rsp_rpm_ff;
   assign div_active = (state_ff == S_QUOT) || (state_ff == S_BLEND);

   always_comb begin
      unique case (csr_paddr[2])
         REG_DEBOUNCE: csr_prdata = CSR_DATA_WIDTH'(debounce_ff);
         REG_PPR:      csr_prdata = CSR_DATA_WIDTH'(ppr_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign edge_time  = req_time_us[TIME_WIDTH-1:0];
   assign edge_delta = edge_time - last_edge_ff;
   assign ppr_eff    = (ppr_ff == '0) ? PPR_WIDTH'(1) : ppr_ff;
   assign product    = DW'(period_ff) * DW'(ppr_eff);

   // One restoring division step: bring down the next dividend bit.
   assign trial      = {rem_ff, dvd_ff[SUMW-1]};
   assign trial_fits = (trial >= {1'b0, dvs_ff});
   assign step_rem   = trial_fits ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
   assign step_quo   = {quo_ff[SUMW-2:0], trial_fits};

   assign instant   = sat_ff ? '1 : quo_ff[QW-1:0];
   assign old_ext   = SUMW'(smoothed_ff);
   assign new_ext   = SUMW'(instant);
   assign blend_sum = (old_ext << 3) - old_ext + (new_ext << 1) + new_ext;

   always_comb begin
      state_in     = state_ff;
      debounce_in  = debounce_ff;
      ppr_in       = ppr_ff;
      last_edge_in = last_edge_ff;
      period_in    = period_ff;
      smoothed_in  = smoothed_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      sat_in       = sat_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_DEBOUNCE: debounce_in = csr_pwdata[DEBOUNCE_WIDTH-1:0];
            REG_PPR:      ppr_in = csr_pwdata[PPR_WIDTH-1:0];
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_mode == MODE_PULSE) begin
                  if (edge_delta >= TIME_WIDTH'(debounce_ff)) begin
                     period_in    = edge_delta;
                     last_edge_in = edge_time;
                  end
               end else if (period_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            dvs_in   = product;
            sat_in   = (product <= DW'(NUM_HIGH));
            rem_in   = DW'(NUM_HIGH);
            dvd_in   = {NUM_LOW, {SUM_GUARD_BITS{1'b0}}};
            quo_in   = '0;
            cnt_in   = CNTW'(QW - 1);
            state_in = S_QUOT;
         end
         S_QUOT: begin
            rem_in = step_rem;
            dvd_in = dvd_ff << 1;
            quo_in = step_quo;
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == '0) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            dvs_in   = DW'(BLEND_DIVISOR);
            rem_in   = '0;
            dvd_in   = blend_sum;
            quo_in   = '0;
            cnt_in   = CNTW'(SUMW - 1);
            state_in = S_BLEND;
         end
         S_BLEND: begin
            rem_in = step_rem;
            dvd_in = dvd_ff << 1;
            quo_in = step_quo;
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == '0) begin
               smoothed_in = step_quo[QW-1:0];
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rpm_in   = smoothed_ff[QW-1:RPM_FRAC_BITS];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         debounce_ff  <= DEBOUNCE_RESET;
         ppr_ff       <= PPR_RESET;
         last_edge_ff <= '0;
         period_ff    <= '0;
         smoothed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         debounce_ff  <= debounce_in;
         ppr_ff       <= ppr_in;
         last_edge_ff <= last_edge_in;
         period_ff    <= period_in;
         smoothed_ff  <= smoothed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rpm_ff <= rsp_rpm_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      sat_ff     <= sat_in;
   end

   `FTRM_ASSERT_NEXT(a_update_starts, clock, reset,
      req_take && req_mode == MODE_UPDATE && period_ff != '0, state_ff == S_MUL)
   `FTRM_ASSERT_NEXT(a_edge_keeps_speed, clock, reset,
      req_take && req_mode == MODE_PULSE, $stable(smoothed_ff))
   `FTRM_ASSERT_SAME(a_result_from_done, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == S_DONE)
   `FTRM_ASSERT_SAME(a_rem_below_divisor, clock, reset,
      div_active && !(state_ff == S_QUOT && sat_ff), rem_ff < dvs_ff)

endmodule
